FILE: rtl/core/ef_pkg.sv
package ef_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int ENV_W    = 16;
  localparam int INTEG_W  = 40;
  localparam int LEVEL_W  = 32;
  localparam int DIFF_W   = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 57;

  localparam int SQRT_STEPS = LEVEL_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  localparam logic [COEF_W-1:0] HP_COEFF_RST = 16'd65208;
  localparam logic [COEF_W-1:0] LP_COEFF_RST = 16'd655;

  localparam logic [CFG_IDX_W-1:0] CFG_HP_COEFF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_COEFF = 1'd1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_XS,
    OP_ILO,
    OP_IHI,
    OP_WSUM,
    OP_WSAT,
    OP_DIFF,
    OP_L1,
    OP_L2,
    OP_L3,
    OP_LSUM,
    OP_SQRT,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XS,
    ST_ILO,
    ST_IHI,
    ST_WSUM,
    ST_WSAT,
    ST_DIFF,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_LSUM,
    ST_SQRT,
    ST_OUT
  } st_t;

  typedef struct packed {
    op_t op;
  } ef_cmd_t;

endpackage

FILE: rtl/core/ef_ifs.sv
interface ef_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ef_pkg::SAMPLE_W-1:0]  sample;
  logic                                clear_first;

  modport source (output valid, sample, clear_first, input ready);
  modport sink (input valid, sample, clear_first, output ready);
endinterface

interface ef_out_if;
  logic                        valid;
  logic                        ready;
  logic [ef_pkg::ENV_W-1:0]    envelope;

  modport source (output valid, envelope, input ready);
  modport sink (input valid, envelope, output ready);
endinterface

FILE: rtl/core/envelope_follower.sv
// envelope follower: one signed q1.15 sample word in, one unsigned q1.15
// envelope word out. the sample is scaled by (1+alpha)/2, run through a
// saturating 40-bit leaky integrator (dc removal), the capped rectified change
// is smoothed by a one-pole lowpass into a 32-bit level, and the output is the
// floor square root of that level. clear_first zeroes both state registers
// before its sample is used. one item is in work at a time and passes, from
// accept to the next accept, through the accept cycle, ten steps that
// share one 18x25 multiplier and the accumulator, sixteen steps of the
// bit-serial square root, and one step to load the output register. the
// output register lets the next sample be accepted while the last envelope
// word waits; a finished word only waits in the output step if the previous
// one is still not taken. the user writes hp_coeff (index 0) and lp_coeff
// (index 1) through the cfg port only while idle; the block does not enforce it.
module envelope_follower (
  input  logic                            clk,
  input  logic                            rst_n,
  ef_in_if.sink                           in_ch,
  ef_out_if.source                        out_ch,
  input  logic                            cfg_we,
  input  logic [ef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ef_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // command word from sequencer to datapath
  ef_pkg::ef_cmd_t cmd;

  // sequencer: handshakes, step order, root step count
  ef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: coefficients, state, shared multiplier, root unit
  ef_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_sample      (in_ch.sample),
    .in_clear_first (in_ch.clear_first),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .envelope       (out_ch.envelope)
  );

`ifndef SYNTHESIS
  // a new word must never overwrite one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ef_pkg::OP_OUT) |-> (!out_ch.valid || out_ch.ready))
    else $error("output word overwritten while pending");

  // only one item in work: no accept in the cycle after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word accepted while busy");

  // sample capture happens exactly on an accept
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ef_pkg::OP_LOAD) |-> (in_ch.valid && in_ch.ready))
    else $error("sample loaded without accept");

  // a finished word appears in the cycle after the output step
  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ef_pkg::OP_OUT) |=> out_ch.valid)
    else $error("output valid missing after load");
`endif

endmodule

FILE: rtl/core/ef_ctrl.sv
module ef_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output ef_pkg::ef_cmd_t cmd
);

  ef_pkg::st_t                   st_r, st_nxt;
  logic [ef_pkg::SQRT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ef_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    cmd.op   = ef_pkg::OP_NOP;
    in_ready = 1'b0;
    case (st_r)
      ef_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = ef_pkg::OP_LOAD;
          st_nxt = ef_pkg::ST_XS;
        end
      end
      ef_pkg::ST_XS: begin
        cmd.op = ef_pkg::OP_XS;
        st_nxt = ef_pkg::ST_ILO;
      end
      ef_pkg::ST_ILO: begin
        cmd.op = ef_pkg::OP_ILO;
        st_nxt = ef_pkg::ST_IHI;
      end
      ef_pkg::ST_IHI: begin
        cmd.op = ef_pkg::OP_IHI;
        st_nxt = ef_pkg::ST_WSUM;
      end
      ef_pkg::ST_WSUM: begin
        cmd.op = ef_pkg::OP_WSUM;
        st_nxt = ef_pkg::ST_WSAT;
      end
      ef_pkg::ST_WSAT: begin
        cmd.op = ef_pkg::OP_WSAT;
        st_nxt = ef_pkg::ST_DIFF;
      end
      ef_pkg::ST_DIFF: begin
        cmd.op = ef_pkg::OP_DIFF;
        st_nxt = ef_pkg::ST_L1;
      end
      ef_pkg::ST_L1: begin
        cmd.op = ef_pkg::OP_L1;
        st_nxt = ef_pkg::ST_L2;
      end
      ef_pkg::ST_L2: begin
        cmd.op = ef_pkg::OP_L2;
        st_nxt = ef_pkg::ST_L3;
      end
      ef_pkg::ST_L3: begin
        cmd.op = ef_pkg::OP_L3;
        st_nxt = ef_pkg::ST_LSUM;
      end
      ef_pkg::ST_LSUM: begin
        cmd.op  = ef_pkg::OP_LSUM;
        cnt_nxt = '0;
        st_nxt  = ef_pkg::ST_SQRT;
      end
      ef_pkg::ST_SQRT: begin
        cmd.op  = ef_pkg::OP_SQRT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ef_pkg::SQRT_CNT_W'(ef_pkg::SQRT_STEPS - 1)) begin
          st_nxt = ef_pkg::ST_OUT;
        end
      end
      ef_pkg::ST_OUT: begin
        // hold until the previous word has left the output register
        if (!out_valid_r || out_ready) begin
          cmd.op = ef_pkg::OP_OUT;
          st_nxt = ef_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = ef_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || (cmd.op == ef_pkg::OP_OUT);
  assign out_valid     = out_valid_r;

endmodule

FILE: rtl/core/ef_dp.sv
module ef_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ef_pkg::ef_cmd_t                     cmd,
  input  logic signed [ef_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                in_clear_first,
  input  logic                                cfg_we,
  input  logic [ef_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ef_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic [ef_pkg::ENV_W-1:0]            envelope
);

  localparam logic signed [41:0] W_MAX = 42'sh007F_FFFF_FFFF;
  localparam logic signed [41:0] W_MIN = -42'sh0080_0000_0000;

  logic [ef_pkg::COEF_W-1:0]              hp_r, lp_r;
  logic signed [ef_pkg::INTEG_W-1:0]      integ_r;
  logic [ef_pkg::LEVEL_W-1:0]             level_r;

  logic signed [ef_pkg::SAMPLE_W-1:0]     x_r;
  logic signed [ef_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [ef_pkg::ACC_W-1:0]        acc_r;
  logic signed [16:0]                     xs_r;
  logic signed [ef_pkg::INTEG_W-1:0]      wn_r;
  logic [ef_pkg::DIFF_W-1:0]              d_r;
  logic [ef_pkg::LEVEL_W-1:0]             rem_r, root_r, bit_r;
  logic [ef_pkg::ENV_W-1:0]               env_r;

  logic signed [ef_pkg::MUL_A_W-1:0]      ma;
  logic signed [ef_pkg::MUL_B_W-1:0]      mb;
  logic [16:0]                            nb;
  logic signed [41:0]                     wsum;
  logic signed [ef_pkg::INTEG_W-1:0]      wn_nxt;
  logic signed [ef_pkg::INTEG_W:0]        delta;
  logic [ef_pkg::INTEG_W:0]               delta_abs;
  logic [ef_pkg::DIFF_W-1:0]              d_nxt;
  logic signed [ef_pkg::ACC_W-1:0]        lsum;
  logic [ef_pkg::LEVEL_W-1:0]             level_nxt;
  logic [ef_pkg::LEVEL_W-1:0]             trial;
  logic                                   take;

  // shared multiplier operands
  assign nb = 17'(18'd65536 - {2'b0, lp_r});

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      ef_pkg::OP_XS: begin
        ma = ef_pkg::MUL_A_W'(x_r);
        mb = $signed({8'b0, 1'b1, hp_r});
      end
      ef_pkg::OP_ILO: begin
        ma = $signed({2'b0, hp_r});
        mb = $signed({1'b0, integ_r[23:0]});
      end
      ef_pkg::OP_IHI: begin
        ma = $signed({2'b0, hp_r});
        mb = ef_pkg::MUL_B_W'($signed(integ_r[39:24]));
      end
      ef_pkg::OP_L1: begin
        ma = $signed({2'b0, lp_r});
        mb = $signed({8'b0, d_r});
      end
      ef_pkg::OP_L2: begin
        ma = $signed({1'b0, nb});
        mb = $signed({9'b0, level_r[15:0]});
      end
      ef_pkg::OP_L3: begin
        ma = $signed({1'b0, nb});
        mb = $signed({9'b0, level_r[31:16]});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_nxt = ma * mb;

  // integrator update with saturation to the 40-bit range
  always_comb begin
    wsum = 42'(xs_r) + 42'($signed(acc_r[ef_pkg::ACC_W-1:16]));
    if (wsum > W_MAX) begin
      wn_nxt = W_MAX[39:0];
    end else if (wsum < W_MIN) begin
      wn_nxt = W_MIN[39:0];
    end else begin
      wn_nxt = wsum[39:0];
    end
  end

  // rectified change, capped
  assign delta     = 41'(wn_r) - 41'(integ_r);
  assign delta_abs = delta[40] ? 41'(-delta) : 41'(delta);
  assign d_nxt     = (delta_abs > 41'd131071) ? 17'd131071 : delta_abs[16:0];

  assign lsum      = acc_r + (ef_pkg::ACC_W'(prod_r) <<< 16);
  assign level_nxt = lsum[47:16];

  // one root step per cycle
  assign trial = root_r + bit_r;
  assign take  = (rem_r >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r    <= ef_pkg::HP_COEFF_RST;
      lp_r    <= ef_pkg::LP_COEFF_RST;
      integ_r <= '0;
      level_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ef_pkg::CFG_HP_COEFF: hp_r <= cfg_wdata;
          ef_pkg::CFG_LP_COEFF: lp_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (cmd.op)
        ef_pkg::OP_LOAD: begin
          if (in_clear_first) begin
            integ_r <= '0;
            level_r <= '0;
          end
        end
        ef_pkg::OP_DIFF: integ_r <= wn_r;
        ef_pkg::OP_LSUM: level_r <= level_nxt;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (cmd.op)
      ef_pkg::OP_LOAD: x_r  <= in_sample;
      ef_pkg::OP_ILO:  xs_r <= prod_r[33:17];
      ef_pkg::OP_IHI:  acc_r <= ef_pkg::ACC_W'(prod_r);
      ef_pkg::OP_WSUM: acc_r <= acc_r + (ef_pkg::ACC_W'(prod_r) <<< 24);
      ef_pkg::OP_WSAT: wn_r <= wn_nxt;
      ef_pkg::OP_DIFF: d_r  <= d_nxt;
      ef_pkg::OP_L2:   acc_r <= ef_pkg::ACC_W'(prod_r) <<< 15;
      ef_pkg::OP_L3:   acc_r <= acc_r + ef_pkg::ACC_W'(prod_r);
      ef_pkg::OP_LSUM: begin
        rem_r  <= level_nxt;
        root_r <= '0;
        bit_r  <= 32'h4000_0000;
      end
      ef_pkg::OP_SQRT: begin
        if (take) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ef_pkg::OP_OUT:  env_r <= root_r[ef_pkg::ENV_W-1:0];
      default: ;
    endcase
  end

  assign envelope = env_r;

endmodule
